### sv/pmfd_pkg.sv
// Package with shared types, constants and codes for the power meter frame decoder.
`timescale 1ns / 1ps
package pmfd_pkg;

   localparam int FRAME_BYTES_DEF   = 24;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int SCALE_W = 48;
   localparam int VAL_W   = 32;
   localparam int PER_W   = 24;
   localparam int CSR_IDX_W = 2;

   localparam logic [7:0] CHECK_BYTE = 8'h5A;
   localparam logic [7:0] STATE_CHIP = 8'hAA;
   localparam logic [7:0] STATE_OK   = 8'h55;
   localparam logic [7:0] STATE_HIGH = 8'hF0;

   localparam logic [CSR_IDX_W-1:0] REG_RELAY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VSCALE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ISCALE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PSCALE = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_LENGTH   = 3'd1;
   localparam logic [2:0] ST_CHECK    = 3'd2;
   localparam logic [2:0] ST_CHECKSUM = 3'd3;
   localparam logic [2:0] ST_CHIP     = 3'd4;
   localparam logic [2:0] ST_REGS     = 3'd5;
   localparam logic [2:0] ST_BADSTATE = 3'd6;
   localparam logic [2:0] ST_RELAYOFF = 3'd7;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       end_of_chunk;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic signed [31:0] voltage_rms;
      logic signed [31:0] current_rms;
      logic signed [31:0] active_power;
      logic signed [31:0] apparent_power;
      logic signed [31:0] power_factor;
      logic [2:0]        overflow_flags;
      logic              new_values;
   } rsp_type;

   typedef enum logic [3:0] {
      SQ_IDLE, SQ_DIV_V, SQ_DIV_I, SQ_DIV_P, SQ_MUL, SQ_MUL_WAIT,
      SQ_DIV_PF, SQ_FIN, SQ_OUT
   } seq_state_type;

   // Divider command and result.
   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [31:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quot;
   } div_res_type;

endpackage

### sv/power_meter_frame_decoder.sv
// Top level of the power meter frame decoder: byte capture, checks and sequencer.
//
// Usage: received bytes enter on the req_ channel, one request per byte, with
// end_of_chunk marking the last byte of a chunk. Bytes without the mark are
// taken in one cycle each and give no result. The marked byte starts the
// evaluation and gives exactly one result on the rsp_ channel.
// A rejected or relay-off chunk goes from the checks straight to the result. A
// good chunk runs each enabled division in turn in the one shared divider (64
// quotient bits each), then the multiply for the apparent power and, unless the
// apparent power is very small, the power factor division.
// req_ready is low from the marked byte until the result has been taken.
// The csr_ port writes relay_on and the three 48-bit scales by index; the user
// must have it written only while the block is idle; the block does not enforce it.
// Reset (synchronous, active high) clears the byte count and sum, the captured frame,
// the stored values and the registers. When the receiver holds rsp_ready low
// the result is held and no further request is taken.
`timescale 1ns / 1ps
module power_meter_frame_decoder
   import pmfd_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SCALE_W-1:0]   csr_data
);

   localparam int FB = FRAME_BYTES_DEF;
   localparam logic signed [31:0] MINUS_ONE = -(32'sd1 <<< FRACTION_BITS);
   localparam logic signed [31:0] SMALL_APP = 32'((1 << FRACTION_BITS) / 10000);

   logic relay_ff;
   logic [SCALE_W-1:0] vsc_ff, isc_ff, psc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff <= 1'b0;
         vsc_ff <= '0;
         isc_ff <= '0;
         psc_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_RELAY:  relay_ff <= csr_data[0];
            REG_VSCALE: vsc_ff <= csr_data;
            REG_ISCALE: isc_ff <= csr_data;
            REG_PSCALE: psc_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Byte capture
   logic [4:0] cnt_ff, cnt_in;
   logic [7:0] sum_ff, sum_in, fstate_ff, fchk_ff, fupd_ff, fsum_ff;
   logic [PER_W-1:0] vper_ff, iper_ff, pper_ff;
   logic acc;
   logic [7:0] b;

   assign acc = req_valid && req_ready;
   assign b = req_data.rx_byte;

   seq_state_type st_ff, st_in;
   logic signed [31:0] v_ff, i_ff, p_ff, a_ff, pf_ff;
   logic signed [31:0] v_in, i_in, p_in, a_in, pf_in;
   logic [2:0] status_ff, status_in, flags_ff, flags_in;
   logic [63:0] prod_ff;
   div_cmd_type dcmd;
   div_res_type dres;

   always_comb begin
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      if (acc) begin
         if (cnt_ff >= 5'd2 && cnt_ff <= 5'(FB - 2)) sum_in = sum_ff + b;
         if (cnt_ff < 5'(FB + 1)) cnt_in = cnt_ff + 5'd1;
         if (req_data.end_of_chunk) begin
            cnt_in = '0;
            sum_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; sum_ff <= '0; fstate_ff <= '0; fchk_ff <= '0;
         fupd_ff <= '0; fsum_ff <= '0; vper_ff <= '0; iper_ff <= '0; pper_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
         if (acc) begin
            if (cnt_ff == 5'd0) fstate_ff <= b;
            if (cnt_ff == 5'd1) fchk_ff <= b;
            if (cnt_ff >= 5'd5 && cnt_ff <= 5'd7) vper_ff <= {vper_ff[15:0], b};
            if (cnt_ff >= 5'd11 && cnt_ff <= 5'd13) iper_ff <= {iper_ff[15:0], b};
            if (cnt_ff >= 5'd17 && cnt_ff <= 5'd19) pper_ff <= {pper_ff[15:0], b};
            if (cnt_ff == 5'd20) fupd_ff <= b;
            if (cnt_ff == 5'(FB - 1)) fsum_ff <= b;
         end
      end
   end

   // Checks use the state after the marked byte is taken; the sum byte may be
   // the marked one, so it and the running sum are registered and looked at in the next cycle.
   logic [4:0] fcnt_ff;
   logic       final_sum_ok;
   logic [7:0] fsumsnap_ff;

   always_ff @(posedge clock) begin
      if (acc && req_data.end_of_chunk) begin
         fcnt_ff <= (cnt_ff < 5'(FB + 1)) ? cnt_ff + 5'd1 : cnt_ff;
         fsumsnap_ff <= (cnt_ff >= 5'd2 && cnt_ff <= 5'(FB - 2)) ? sum_ff + b : sum_ff;
      end
   end
   assign final_sum_ok = (fsum_ff == fsumsnap_ff);

   function automatic logic signed [31:0] sat_pos(input logic [63:0] q);
      return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
   endfunction

   function automatic logic [31:0] mag(input logic signed [31:0] x);
      return x[31] ? 32'(-x) : x;
   endfunction

   logic go;
   logic [63:0] app_mag;
   logic        app_neg;
   logic signed [31:0] app_sat;
   logic [63:0] pf_num;

   assign go = st_ff == SQ_IDLE && acc && req_data.end_of_chunk;
   assign app_neg = v_ff[31] ^ i_ff[31];
   assign app_mag = prod_ff >> FRACTION_BITS;
   assign pf_num  = {32'd0, mag(p_ff)} << FRACTION_BITS;

   always_comb begin
      if (app_neg)
         app_sat = (app_mag >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-app_mag[31:0]);
      else
         app_sat = (app_mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : app_mag[31:0];
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         SQ_IDLE:     if (go) st_in = SQ_FIN;
         SQ_FIN: begin
            if (!relay_ff || fcnt_ff != 5'(FB) || fchk_ff != CHECK_BYTE || !final_sum_ok
                || fstate_ff == STATE_CHIP
                || (fstate_ff != STATE_OK && (fstate_ff & STATE_HIGH) != STATE_HIGH)
                || (fstate_ff != STATE_OK && fstate_ff[0]))
               st_in = SQ_OUT;
            else
               st_in = SQ_DIV_V;
         end
         SQ_DIV_V:    if (!fupd_ff[6] || dres.done) st_in = SQ_DIV_I;
         SQ_DIV_I:    if (!fupd_ff[5] || dres.done) st_in = SQ_DIV_P;
         SQ_DIV_P:    if (!fupd_ff[4] || dres.done) st_in = SQ_MUL;
         SQ_MUL:      st_in = SQ_MUL_WAIT;
         SQ_MUL_WAIT: st_in = SQ_DIV_PF;
         SQ_DIV_PF:   if (a_ff <= SMALL_APP || dres.done) st_in = SQ_OUT;
         SQ_OUT:      if (rsp_ready) st_in = SQ_IDLE;
         default:     st_in = SQ_IDLE;
      endcase
   end

   // Divider started on entry to each enabled divide state; a flag marks issue.
   logic issued_ff, issued_in;

   always_comb begin
      v_in = v_ff; i_in = i_ff; p_in = p_ff; a_in = a_ff; pf_in = pf_ff;
      status_in = status_ff; flags_in = flags_ff;
      issued_in = issued_ff;
      dcmd = '0;
      unique case (st_ff)
         SQ_IDLE: begin
            issued_in = 1'b0;
         end
         SQ_FIN: begin
            flags_in = 3'd0;
            status_in = ST_OK;
            if (!relay_ff) begin
               status_in = ST_RELAYOFF;
               v_in = '0; i_in = '0; p_in = '0; a_in = '0; pf_in = '0;
            end else if (fcnt_ff != 5'(FB)) status_in = ST_LENGTH;
            else if (fchk_ff != CHECK_BYTE) status_in = ST_CHECK;
            else if (!final_sum_ok) status_in = ST_CHECKSUM;
            else if (fstate_ff == STATE_CHIP) begin
               status_in = ST_CHIP;
               v_in = MINUS_ONE; i_in = MINUS_ONE; p_in = MINUS_ONE;
               a_in = MINUS_ONE; pf_in = MINUS_ONE;
            end else if (fstate_ff != STATE_OK) begin
               if ((fstate_ff & STATE_HIGH) != STATE_HIGH) begin
                  status_in = ST_BADSTATE;
                  v_in = MINUS_ONE; i_in = MINUS_ONE; p_in = MINUS_ONE;
                  a_in = MINUS_ONE; pf_in = MINUS_ONE;
               end else begin
                  flags_in = fstate_ff[3:1];
                  if (fstate_ff[0]) begin
                     status_in = ST_REGS;
                     v_in = MINUS_ONE; i_in = MINUS_ONE; p_in = MINUS_ONE;
                     a_in = MINUS_ONE; pf_in = MINUS_ONE;
                  end
               end
            end
         end
         SQ_DIV_V: if (fupd_ff[6]) begin
            if (!issued_ff) begin
               dcmd.start = 1'b1;
               dcmd.num = {16'd0, vsc_ff};
               dcmd.den = {8'd0, vper_ff};
               issued_in = 1'b1;
            end else if (dres.done) begin
               v_in = (vper_ff == '0) ? 32'sh7FFF_FFFF : sat_pos(dres.quot);
               issued_in = 1'b0;
            end
         end
         SQ_DIV_I: if (fupd_ff[5]) begin
            if (!issued_ff) begin
               dcmd.start = 1'b1;
               dcmd.num = {16'd0, isc_ff};
               dcmd.den = {8'd0, iper_ff};
               issued_in = 1'b1;
            end else if (dres.done) begin
               i_in = (iper_ff == '0) ? 32'sh7FFF_FFFF : sat_pos(dres.quot);
               issued_in = 1'b0;
            end
         end
         SQ_DIV_P: if (fupd_ff[4]) begin
            if (!issued_ff) begin
               dcmd.start = 1'b1;
               dcmd.num = {16'd0, psc_ff};
               dcmd.den = {8'd0, pper_ff};
               issued_in = 1'b1;
            end else if (dres.done) begin
               p_in = (pper_ff == '0) ? 32'sh7FFF_FFFF : sat_pos(dres.quot);
               issued_in = 1'b0;
            end
         end
         SQ_MUL: ;
         SQ_MUL_WAIT: a_in = app_sat;
         SQ_DIV_PF: begin
            if (a_ff <= SMALL_APP) pf_in = '0;
            else if (!issued_ff) begin
               dcmd.start = 1'b1;
               dcmd.num = pf_num;
               dcmd.den = a_ff;
               issued_in = 1'b1;
            end else if (dres.done) begin
               if (p_ff[31])
                  pf_in = (dres.quot >= 64'h8000_0000) ? 32'sh8000_0000
                                                       : 32'(-dres.quot[31:0]);
               else
                  pf_in = sat_pos(dres.quot);
               issued_in = 1'b0;
            end
         end
         SQ_OUT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_ff == SQ_MUL) prod_ff <= {32'd0, mag(v_ff)} * {32'd0, mag(i_ff)};
      status_ff <= status_in;
      flags_ff <= flags_in;
      if (reset) begin
         st_ff <= SQ_IDLE;
         issued_ff <= 1'b0;
         v_ff <= '0; i_ff <= '0; p_ff <= '0; a_ff <= '0; pf_ff <= '0;
      end else begin
         st_ff <= st_in;
         issued_ff <= issued_in;
         v_ff <= v_in; i_ff <= i_in; p_ff <= p_in; a_ff <= a_in; pf_ff <= pf_in;
      end
   end

   pmfd_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (dcmd),
      .res   (dres)
   );

   assign req_ready = (st_ff == SQ_IDLE);
   assign rsp_valid = (st_ff == SQ_OUT);

   always_comb begin
      rsp_data.status = status_ff;
      rsp_data.voltage_rms = v_ff;
      rsp_data.current_rms = i_ff;
      rsp_data.active_power = p_ff;
      rsp_data.apparent_power = a_ff;
      rsp_data.power_factor = pf_ff;
      rsp_data.overflow_flags = flags_ff;
      rsp_data.new_values = (status_ff == ST_OK);
   end

`ifndef SYNTHESIS
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request taken while result pending");
   a_ok_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.new_values == (rsp_data.status == ST_OK)))
      else $error("new_values disagrees with status");
   a_mark_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.end_of_chunk) |=> st_ff == SQ_FIN)
      else $error("marked byte did not start evaluation");
`endif

endmodule

### sv/pmfd_divider.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pmfd_divider
   import pmfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_res_type res
);

   logic [63:0] quot_ff, quot_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [32:0] sh;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sh      = {rem_ff, quot_ff[63]};
      trial   = sh - {1'b0, den_ff};
      if (cmd.start) begin
         quot_in = cmd.num;
         rem_in  = '0;
         den_in  = cmd.den;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in  = trial[31:0];
            quot_in = {quot_ff[62:0], 1'b1};
         end else begin
            rem_in  = sh[31:0];
            quot_in = {quot_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign res.done = done_ff;
   assign res.quot = quot_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !cmd.start) else $error("divider restarted while busy");
   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider busy after done");
`endif

endmodule

### tb/sv/tb_power_meter_frame_decoder.sv
// Self-checking testbench for the power meter frame decoder.
`timescale 1ns / 1ps
module tb_power_meter_frame_decoder;
   import pmfd_pkg::*;

   localparam int FRAC = FRACTION_BITS_DEF;
   localparam int SETTLE_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 20000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_RELAY;
   logic [SCALE_W-1:0]   csr_data = '0;

   power_meter_frame_decoder i_dut (.*);

   always #5 clock = ~clock;

   // Predictor state.
   logic        relay_on;
   logic [47:0] v_scale, i_scale, p_scale;
   int unsigned byte_count;
   logic [7:0]  running_sum, f_state, f_check, f_update, f_sum;
   logic [23:0] v_period, i_period, p_period;
   logic signed [31:0] v_val, i_val, p_val, s_val, pf_val;

   rsp_type     expected_results[$];
   int          mismatches = 0;
   int          checked = 0;
   int          chunks_sent = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          idle_cycles = 0;
   logic [7:0]  status_seen = '0;
   logic [2:0]  last_status = '0;

   function automatic logic signed [31:0] saturate(logic [63:0] mag, logic neg);
      if (neg) begin
         if (mag >= 64'h8000_0000) return 32'sh8000_0000;
         return -$signed(mag[31:0]);
      end
      if (mag > 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
      return mag[31:0];
   endfunction

   function automatic logic signed [31:0] scale_quotient(logic [47:0] sc, logic [23:0] per);
      if (per == 0) return 32'sh7FFF_FFFF;
      return saturate({16'd0, sc} / {40'd0, per}, 1'b0);
   endfunction

   function automatic logic [63:0] magnitude(logic signed [31:0] v);
      return v < 0 ? 64'd0 - {{32{v[31]}}, v} : {32'd0, v};
   endfunction

   task automatic set_values(logic signed [31:0] v);
      v_val = v; i_val = v; p_val = v; s_val = v; pf_val = v;
   endtask

   task automatic predictor_reset();
      relay_on = 0; v_scale = 0; i_scale = 0; p_scale = 0;
      byte_count = 0; running_sum = 0;
      f_state = 0; f_check = 0; f_update = 0; f_sum = 0;
      v_period = 0; i_period = 0; p_period = 0;
      set_values(0);
   endtask

   // Works out the result, if any, caused by one accepted request.
   task automatic predict_byte(req_type r);
      rsp_type     res;
      logic [2:0]  st;
      logic [2:0]  flg;
      logic [63:0] m;
      int unsigned pos;
      pos = byte_count;
      if (pos < 24) begin
         if (pos == 0) f_state = r.rx_byte;
         if (pos == 1) f_check = r.rx_byte;
         if (pos >= 2 && pos <= 22) running_sum = running_sum + r.rx_byte;
         if (pos >= 5 && pos <= 7) v_period = {v_period[15:0], r.rx_byte};
         if (pos >= 11 && pos <= 13) i_period = {i_period[15:0], r.rx_byte};
         if (pos >= 17 && pos <= 19) p_period = {p_period[15:0], r.rx_byte};
         if (pos == 20) f_update = r.rx_byte;
         if (pos == 23) f_sum = r.rx_byte;
      end
      if (byte_count < 25) byte_count++;
      if (!r.end_of_chunk) return;
      flg = 0;
      if (!relay_on) begin
         set_values(0); st = ST_RELAYOFF;
      end else if (byte_count != 24) st = ST_LENGTH;
      else if (f_check != CHECK_BYTE) st = ST_CHECK;
      else if (f_sum != running_sum) st = ST_CHECKSUM;
      else if (f_state == STATE_CHIP) begin
         set_values(-(32'sd1 <<< FRAC)); st = ST_CHIP;
      end else if (f_state != STATE_OK && (f_state & STATE_HIGH) != STATE_HIGH) begin
         set_values(-(32'sd1 <<< FRAC)); st = ST_BADSTATE;
      end else if (f_state != STATE_OK && f_state[0]) begin
         flg = f_state[3:1];
         set_values(-(32'sd1 <<< FRAC)); st = ST_REGS;
      end else begin
         if (f_state != STATE_OK) flg = f_state[3:1];
         st = ST_OK;
         if (f_update[6]) v_val = scale_quotient(v_scale, v_period);
         if (f_update[5]) i_val = scale_quotient(i_scale, i_period);
         if (f_update[4]) p_val = scale_quotient(p_scale, p_period);
         m = magnitude(v_val) * magnitude(i_val);
         s_val = saturate(m >> FRAC, (v_val < 0) != (i_val < 0));
         if (s_val <= ((1 << FRAC) / 10000)) pf_val = 0;
         else pf_val = saturate((magnitude(p_val) << FRAC) / magnitude(s_val), p_val < 0);
      end
      byte_count = 0;
      running_sum = 0;
      res.status = st;
      res.voltage_rms = v_val;
      res.current_rms = i_val;
      res.active_power = p_val;
      res.apparent_power = s_val;
      res.power_factor = pf_val;
      res.overflow_flags = flg;
      res.new_values = (st == ST_OK);
      expected_results.push_back(res);
      status_seen[st] = 1'b1;
   endtask

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("error: %s got %h expected %h (result %0d)", field, got, want, checked);
      mismatches++;
   endtask

   // Receiver: checks each accepted result and randomly stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_data.status, 0);
            end else begin
               rsp_type e;
               last_status = rsp_data.status;
               e = expected_results.pop_front();
               if (rsp_data.status != e.status)
                  report_mismatch("status", rsp_data.status, e.status);
               if (rsp_data.voltage_rms != e.voltage_rms)
                  report_mismatch("voltage_rms", rsp_data.voltage_rms, e.voltage_rms);
               if (rsp_data.current_rms != e.current_rms)
                  report_mismatch("current_rms", rsp_data.current_rms, e.current_rms);
               if (rsp_data.active_power != e.active_power)
                  report_mismatch("active_power", rsp_data.active_power, e.active_power);
               if (rsp_data.apparent_power != e.apparent_power)
                  report_mismatch("apparent_power", rsp_data.apparent_power,
                                  e.apparent_power);
               if (rsp_data.power_factor != e.power_factor)
                  report_mismatch("power_factor", rsp_data.power_factor, e.power_factor);
               if (rsp_data.overflow_flags != e.overflow_flags)
                  report_mismatch("overflow_flags", rsp_data.overflow_flags,
                                  e.overflow_flags);
               if (rsp_data.new_values != e.new_values)
                  report_mismatch("new_values", rsp_data.new_values, e.new_values);
            end
            checked++;
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog on cycles with no accepted request or result.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("power_meter_frame_decoder: mismatch");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [47:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_RELAY:  relay_on = value[0];
         REG_VSCALE: v_scale = value;
         REG_ISCALE: i_scale = value;
         REG_PSCALE: p_scale = value;
         default: ;
      endcase
   endtask

   // Drops the request valid; the callers use it after the last request is taken.
   task automatic stop_sending();
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      stop_sending();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sends one request, idling first at random, and predicts at acceptance.
   // Valid stays high after acceptance so that requests can follow back to back.
   task automatic send_byte(logic [7:0] b, logic eoc);
      req_type r;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      r.rx_byte = b;
      r.end_of_chunk = eoc;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_byte(r);
      if (eoc) chunks_sent++;
   endtask

   function automatic logic [23:0] random_period();
      case ($urandom_range(5))
         0: return 24'd0;
         1: return 24'hFFFFFF;
         2: return $urandom_range(1, 16);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] random_state();
      case ($urandom_range(9))
         0: return STATE_CHIP;
         1: return $urandom;
         2, 3, 4: return STATE_HIGH | ($urandom_range(15) & 4'hE);
         5: return STATE_HIGH | $urandom_range(15);
         default: return STATE_OK;
      endcase
   endfunction

   // Sends a 24-byte chunk, optionally broken in a chosen way or of a wrong length.
   task automatic send_frame(logic [7:0] st, logic [7:0] upd, logic [23:0] vp,
                             logic [23:0] ip, logic [23:0] pp, int fault);
      logic [7:0] fr[24];
      logic [7:0] sum;
      int         len;
      foreach (fr[k]) fr[k] = $urandom;
      fr[0] = st;
      fr[1] = CHECK_BYTE;
      {fr[5], fr[6], fr[7]} = vp;
      {fr[11], fr[12], fr[13]} = ip;
      {fr[17], fr[18], fr[19]} = pp;
      fr[20] = upd;
      sum = 0;
      for (int k = 2; k <= 22; k++) sum += fr[k];
      fr[23] = sum;
      len = 24;
      if (fault == 1) fr[1] = fr[1] ^ (8'd1 << $urandom_range(7));
      if (fault == 2) fr[23] = fr[23] ^ (8'd1 << $urandom_range(7));
      if (fault == 3) len = $urandom_range(1, 23);
      if (fault == 4) len = $urandom_range(25, 30);
      for (int k = 0; k < len; k++) send_byte(k < 24 ? fr[k] : 8'($urandom), k == len - 1);
   endtask

   task automatic random_scales();
      write_reg(REG_VSCALE, {$urandom, $urandom} >> $urandom_range(16, 47));
      write_reg(REG_ISCALE, {$urandom, $urandom} >> $urandom_range(16, 47));
      write_reg(REG_PSCALE, {$urandom, $urandom} >> $urandom_range(16, 47));
   endtask

   // Directed table: state byte, update bits, fault kind, expected status.
   typedef struct {
      logic [7:0] state_byte;
      logic [7:0] update_bits;
      int         fault;
      logic [2:0] want_status;
   } frame_row;

   frame_row directed_rows[] = '{
      '{STATE_OK,   8'h70, 0, ST_OK},
      '{STATE_OK,   8'h70, 1, ST_CHECK},
      '{STATE_OK,   8'h70, 2, ST_CHECKSUM},
      '{STATE_OK,   8'h70, 3, ST_LENGTH},
      '{STATE_OK,   8'h70, 4, ST_LENGTH},
      '{STATE_CHIP, 8'h70, 0, ST_CHIP},
      '{8'hF1,      8'h70, 0, ST_REGS},
      '{8'h12,      8'h70, 0, ST_BADSTATE},
      '{8'hFE,      8'hFF, 0, ST_OK},
      '{8'hF0,      8'h00, 0, ST_OK}
   };

   initial begin
      int n;
      predictor_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Relay off: every chunk zeroes the values, a lone marked byte too.
      send_byte(8'hFF, 1'b1);
      send_frame(STATE_OK, 8'h70, 24'd1, 24'd1, 24'd1, 0);
      wait_drained();

      write_reg(REG_RELAY, 48'd1);
      write_reg(REG_VSCALE, 48'hFFFF_FFFF_FFFF);
      write_reg(REG_ISCALE, 48'd0);
      write_reg(REG_PSCALE, 48'h0001_0000_0000);
      foreach (directed_rows[k]) begin
         send_frame(directed_rows[k].state_byte, directed_rows[k].update_bits,
                    k == 0 ? 24'd0 : 24'hFFFFFF, 24'd1, 24'd7,
                    directed_rows[k].fault);
         stop_sending();
         while (expected_results.size() != 0) @(posedge clock);
         if (last_status !== directed_rows[k].want_status)
            report_mismatch("directed status", 32'(last_status),
                            32'(directed_rows[k].want_status));
      end
      wait_drained();
      write_reg(REG_ISCALE, 48'hFFFF_FFFF_FFFF);
      send_frame(STATE_OK, 8'h70, 24'd1, 24'd1, 24'd1, 0);
      wait_drained();

      // Random phases with varied idling and register settings.
      n = 0;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         wait_drained();
         write_reg(REG_RELAY, (phase == 5) ? 48'd0 : 48'd1);
         if (phase == 6) begin
            write_reg(REG_VSCALE, 48'd0);
            write_reg(REG_ISCALE, 48'hFFFF_FFFF_FFFF);
            write_reg(REG_PSCALE, 48'd0);
         end else begin
            random_scales();
         end
         for (int c = 0; c < 11; c++) begin
            int f;
            f = $urandom_range(9);
            if (f >= 5) f = 0;
            if ($urandom_range(9) == 0) begin
               // Noise: a short run of raw bytes, the last one marked.
               repeat ($urandom_range(1, 4)) send_byte($urandom, 1'b0);
               send_byte($urandom, 1'b1);
            end else begin
               send_frame(random_state(), $urandom, random_period(), random_period(),
                          random_period(), f);
            end
            // Hold off now and then until every result is back.
            if (c == 5) begin
               stop_sending();
               while (expected_results.size() != 0) @(posedge clock);
            end
         end
      end
      wait_drained();

      $display("covered %0d chunks, %0d results checked, status codes seen %b",
               chunks_sent, checked, status_seen);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("power_meter_frame_decoder: match");
      end else begin
         $display("power_meter_frame_decoder: mismatch");
      end
      $finish;
   end
endmodule
